// ----- rtl/tass_pkg.sv -----
// Package for the trigger-advanced sequential switch.
// It holds the sizes, the trigger state and register codes, and the port search function.
// It has no dependencies.
package tass_pkg;

	localparam int PORTS       = 8;
	localparam int HALF_PORTS  = PORTS / 2;
	localparam int PORT_W      = $clog2(PORTS);
	localparam int SAMPLE_BITS = 16;
	localparam int THRESH_W    = 16;
	localparam int CFG_ADDR_W  = 2;

	localparam int IN_DATA_W   = 64;
	localparam int OUT_DATA_W  = PORTS * SAMPLE_BITS + PORTS;

	localparam logic [1:0] TRIG_UNKNOWN = 2'd0;
	localparam logic [1:0] TRIG_LOW     = 2'd1;
	localparam logic [1:0] TRIG_HIGH    = 2'd2;

	localparam logic [CFG_ADDR_W-1:0] REG_BANK_MODE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOW_THR   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THR  = 2'd2;

	localparam logic signed [THRESH_W-1:0] HIGH_THR_RESET = 16'sd2048;

	typedef struct packed {
		logic              found;
		logic [PORT_W-1:0] idx;
	} port_pick_t;

	// Finds the next patched port after cur, wrapping inside its bank.
	// In split mode the bank is the half of the ports that holds cur.
	function automatic port_pick_t next_port(logic [PORT_W-1:0] cur, logic [PORTS-1:0] mask,
		logic split);
		port_pick_t        r;
		logic [PORT_W-1:0] cand;
		r.found = 1'b0;
		r.idx   = cur;
		for (int k = PORTS - 1; k >= 1; k--) begin
			if (split) begin
				cand = {cur[PORT_W-1], (PORT_W-1)'(cur[PORT_W-2:0] + (PORT_W-1)'(k))};
			end else begin
				cand = cur + PORT_W'(k);
			end
			if ((!split || k < HALF_PORTS) && mask[cand]) begin
				r.found = 1'b1;
				r.idx   = cand;
			end
		end
		return r;
	endfunction

endpackage

// ----- rtl/trigger_advanced_sequential_switch_unit.sv -----
// Top level of the trigger-advanced sequential switch.
// It uses tass_pkg for sizes, codes and the wrap-around port search.
//
// Channel  | Direction | Fields (lowest bit first)
// s_axis   | in        | trigger_level, trigger_connected, signal_a, signal_a_connected,
//          |           | signal_b, signal_b_connected, port_connected_mask
// m_axis   | out       | port0_value .. port7_value, light_mask
// cfg      | in        | bank_mode, low_threshold, high_threshold by index
//
// The trigger, the port search and the held-value update are one combinational pass
// from the accepted item into the result register.
// A new item is taken in every cycle while the result register is empty or being read.
// Reset zeroes held values, mode, low thr; high thr 2048, trigger unknown, sel 0 and 4.
// A stall on m_axis holds the result and stops s_axis until it is taken.
module trigger_advanced_sequential_switch_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// trigger_level, trigger_connected, signal_a, signal_a_connected, signal_b,
	// signal_b_connected, port_connected_mask, zero fill
	input  logic [tass_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// port0_value .. port7_value, light_mask
	output logic [tass_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [tass_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [tass_pkg::THRESH_W-1:0]      cfg_wdata
);

	localparam int PW = tass_pkg::PORT_W;
	localparam int SB = tass_pkg::SAMPLE_BITS;

	logic                                 bank_mode_q;
	logic signed [tass_pkg::THRESH_W-1:0] low_thr_q;
	logic signed [tass_pkg::THRESH_W-1:0] high_thr_q;
	logic [1:0]                           trig_q;
	logic [PW-1:0]                        sel_a_q;
	logic [PW-1:0]                        sel_b_q;
	logic [SB-1:0]                        held_q [tass_pkg::PORTS];
	logic                                 out_valid_q;
	logic [SB-1:0]                        out_val_q [tass_pkg::PORTS];
	logic [tass_pkg::PORTS-1:0]           out_light_q;

	logic signed [15:0]         level;
	logic                       trig_con;
	logic [SB-1:0]              sig_a;
	logic                       a_con;
	logic [SB-1:0]              sig_b;
	logic                       b_con;
	logic [tass_pkg::PORTS-1:0] mask;

	logic                       in_fire;
	logic [1:0]                 trig_cur;
	logic [1:0]                 trig_n;
	logic                       rise;
	logic [PW-1:0]              sel_a_f;
	logic [PW-1:0]              sel_b_f;
	tass_pkg::port_pick_t       pick_a;
	tass_pkg::port_pick_t       pick_b;
	logic [PW-1:0]              sel_a_n;
	logic [PW-1:0]              sel_b_n;
	logic [SB-1:0]              held_n [tass_pkg::PORTS];
	logic [tass_pkg::PORTS-1:0] light_n;

	assign level    = s_axis_tdata[15:0];
	assign trig_con = s_axis_tdata[16];
	assign sig_a    = s_axis_tdata[32:17];
	assign a_con    = s_axis_tdata[33];
	assign sig_b    = s_axis_tdata[49:34];
	assign b_con    = s_axis_tdata[50];
	assign mask     = s_axis_tdata[58:51];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;

	always_comb begin
		for (int i = 0; i < tass_pkg::PORTS; i++) begin
			m_axis_tdata[i*SB +: SB] = out_val_q[i];
		end
		m_axis_tdata[tass_pkg::PORTS*SB +: tass_pkg::PORTS] = out_light_q;
	end

	always_comb begin
		trig_cur = (trig_q == tass_pkg::TRIG_LOW || trig_q == tass_pkg::TRIG_HIGH) ?
			trig_q : tass_pkg::TRIG_UNKNOWN;
		trig_n = trig_cur;
		rise   = 1'b0;
		if (trig_con) begin
			unique case (trig_cur)
				tass_pkg::TRIG_LOW: begin
					if (level >= high_thr_q) begin
						trig_n = tass_pkg::TRIG_HIGH;
						rise   = 1'b1;
					end
				end
				tass_pkg::TRIG_HIGH: begin
					if (level <= low_thr_q) trig_n = tass_pkg::TRIG_LOW;
				end
				default: begin
					if (level >= high_thr_q) trig_n = tass_pkg::TRIG_HIGH;
					else if (level <= low_thr_q) trig_n = tass_pkg::TRIG_LOW;
					else trig_n = tass_pkg::TRIG_UNKNOWN;
				end
			endcase
		end
	end

	always_comb begin
		sel_a_f = bank_mode_q ? {1'b0, sel_a_q[PW-2:0]} : sel_a_q;
		sel_b_f = bank_mode_q ? {1'b1, sel_b_q[PW-2:0]} : sel_b_q;
		pick_a  = tass_pkg::next_port(sel_a_f, mask, bank_mode_q);
		pick_b  = tass_pkg::next_port(sel_b_f, mask, 1'b1);
		sel_a_n = (rise && pick_a.found) ? pick_a.idx : sel_a_f;
		sel_b_n = (bank_mode_q && rise && pick_b.found) ? pick_b.idx : sel_b_f;

		held_n = held_q;
		if (rise && pick_a.found) held_n[sel_a_f] = '0;
		if (bank_mode_q && rise && pick_b.found) held_n[sel_b_f] = '0;
		if (a_con && mask[sel_a_n]) held_n[sel_a_n] = sig_a;
		if (bank_mode_q && b_con && mask[sel_b_n]) held_n[sel_b_n] = sig_b;

		light_n = '0;
		light_n[sel_a_n] = 1'b1;
		if (bank_mode_q) light_n[sel_b_n] = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_mode_q <= 1'b0;
			low_thr_q   <= '0;
			high_thr_q  <= tass_pkg::HIGH_THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tass_pkg::REG_BANK_MODE: bank_mode_q <= cfg_wdata[0];
				tass_pkg::REG_LOW_THR:   low_thr_q   <= cfg_wdata;
				tass_pkg::REG_HIGH_THR:  high_thr_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_q  <= tass_pkg::TRIG_UNKNOWN;
			sel_a_q <= '0;
			sel_b_q <= PW'(tass_pkg::HALF_PORTS);
			for (int i = 0; i < tass_pkg::PORTS; i++) held_q[i] <= '0;
		end else if (in_fire) begin
			trig_q  <= trig_n;
			sel_a_q <= sel_a_n;
			sel_b_q <= sel_b_n;
			held_q  <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_val_q   <= held_n;
			out_light_q <= light_n;
		end
	end

	a_fire_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> m_axis_tvalid)
		else $error("accepted item produced no result");

	a_banks_folded: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && bank_mode_q) |=> (!sel_a_q[PW-1] && sel_b_q[PW-1]))
		else $error("bank selection outside its bank");

	a_light_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($countones(out_light_q) == 1 || $countones(out_light_q) == 2))
		else $error("light mask has wrong number of bits");

	a_trig_code: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && rise) |=> (trig_q == tass_pkg::TRIG_HIGH))
		else $error("rising edge did not leave trigger high");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the trigger-advanced sequential switch unit.
// It predicts every result item in its own model of the switch and compares it field by field.
// It depends on tass_pkg and trigger_advanced_sequential_switch_unit.
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PW          = tass_pkg::PORT_W;
	localparam int TW          = tass_pkg::THRESH_W;
	localparam int NP          = tass_pkg::PORTS;
	localparam int HP          = tass_pkg::HALF_PORTS;
	localparam int SB          = tass_pkg::SAMPLE_BITS;

	typedef struct packed {
		logic [7:0]             port_mask;
		logic                   sig_b_con;
		logic signed [15:0]     sig_b;
		logic                   sig_a_con;
		logic signed [15:0]     sig_a;
		logic                   trig_con;
		logic signed [15:0]     trigger_level;
	} switch_tick_t;

	typedef struct packed {
		logic [NP-1:0][SB-1:0] port_val;
		logic [NP-1:0]         lights;
	} switch_out_t;

	logic                                clk;
	logic                                arst_n        = 1'b0;
	logic                                s_axis_tvalid = 1'b0;
	logic                                s_axis_tready;
	logic [tass_pkg::IN_DATA_W-1:0]      s_axis_tdata  = '0;
	logic                                m_axis_tvalid;
	logic                                m_axis_tready = 1'b0;
	logic [tass_pkg::OUT_DATA_W-1:0]     m_axis_tdata;
	logic                                cfg_we        = 1'b0;
	logic [tass_pkg::CFG_ADDR_W-1:0]     cfg_addr      = '0;
	logic [TW-1:0]                       cfg_wdata     = '0;

	// Predicted switch state and register copies.
	bit                          cfg_two_bank  = 1'b0;
	int                          cfg_low_thr   = 0;
	int                          cfg_high_thr  = 2048;
	logic [1:0]                  trig_st       = tass_pkg::TRIG_UNKNOWN;
	logic [PW-1:0]               sel_a         = '0;
	logic [PW-1:0]               sel_b         = PW'(HP);
	logic [SB-1:0]               held_val [NP];

	switch_out_t                 pending_outputs [$];
	int                          mismatches    = 0;
	int                          cycle_count   = 0;
	bit                          idle_en       = 1'b1;
	int                          hold_request  = 0;
	int                          hold_left     = 0;
	int                          stall_left    = 0;

	trigger_advanced_sequential_switch_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic bit schmitt_rise(int lvl);
		bit rise;
		rise = 1'b0;
		case (trig_st)
			tass_pkg::TRIG_LOW: begin
				if (lvl >= cfg_high_thr) begin
					trig_st = tass_pkg::TRIG_HIGH;
					rise    = 1'b1;
				end
			end
			tass_pkg::TRIG_HIGH: begin
				if (lvl <= cfg_low_thr)
					trig_st = tass_pkg::TRIG_LOW;
			end
			default: begin
				if (lvl >= cfg_high_thr)
					trig_st = tass_pkg::TRIG_HIGH;
				else if (lvl <= cfg_low_thr)
					trig_st = tass_pkg::TRIG_LOW;
				else
					trig_st = tass_pkg::TRIG_UNKNOWN;
			end
		endcase
		return rise;
	endfunction

	// Searches forward from cur inside [lo, hi), then wraps to lo; clears the old port on a move.
	function automatic int advance_port(int cur, int lo, int hi, logic [7:0] mask);
		for (int i = cur + 1; i < hi; i++) begin
			if (mask[i]) begin
				held_val[cur] = '0;
				return i;
			end
		end
		for (int i = lo; i < cur; i++) begin
			if (mask[i]) begin
				held_val[cur] = '0;
				return i;
			end
		end
		return cur;
	endfunction

	function automatic switch_out_t predict_switch_outputs(switch_tick_t t);
		switch_out_t r;
		bit          rise;
		rise = 1'b0;
		if (cfg_two_bank) begin
			if (sel_a >= HP)
				sel_a = sel_a - PW'(HP);
			if (sel_b < HP)
				sel_b = sel_b + PW'(HP);
		end
		if (t.trig_con)
			rise = schmitt_rise(int'(t.trigger_level));
		if (rise) begin
			if (cfg_two_bank) begin
				sel_a = PW'(advance_port(sel_a, 0, HP, t.port_mask));
				sel_b = PW'(advance_port(sel_b, HP, NP, t.port_mask));
			end else begin
				sel_a = PW'(advance_port(sel_a, 0, NP, t.port_mask));
			end
		end
		if (t.sig_a_con && t.port_mask[sel_a])
			held_val[sel_a] = t.sig_a;
		if (cfg_two_bank && t.sig_b_con && t.port_mask[sel_b])
			held_val[sel_b] = t.sig_b;
		for (int i = 0; i < NP; i++)
			r.port_val[i] = held_val[i];
		r.lights         = '0;
		r.lights[sel_a]  = 1'b1;
		if (cfg_two_bank)
			r.lights[sel_b] = 1'b1;
		return r;
	endfunction

	function automatic void report_mismatch(string what, longint exp_v, longint act_v);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on %s: expected %0h, got %0h", what, exp_v, act_v);
	endfunction

	// Receiver: random short stalls, plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 6);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		switch_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("unexpected item", 0, longint'(m_axis_tdata[63:0]));
			end else begin
				want = pending_outputs.pop_front();
				for (int i = 0; i < NP; i++) begin
					if (m_axis_tdata[i*SB +: SB] !== want.port_val[i])
						report_mismatch($sformatf("port%0d_value", i), want.port_val[i],
							m_axis_tdata[i*SB +: SB]);
				end
				if (m_axis_tdata[NP*SB +: NP] !== want.lights)
					report_mismatch("light_mask", want.lights,
						m_axis_tdata[NP*SB +: NP]);
			end
		end
	end

	task automatic send_tick(input switch_tick_t t);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, t};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_outputs.push_back(predict_switch_outputs(t));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_switch_regs(input bit two_bank, input int low_thr, input int high_thr);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_addr  <= tass_pkg::REG_BANK_MODE;
		cfg_wdata <= TW'(two_bank);
		@(posedge clk);
		cfg_addr  <= tass_pkg::REG_LOW_THR;
		cfg_wdata <= TW'(low_thr);
		@(posedge clk);
		cfg_addr  <= tass_pkg::REG_HIGH_THR;
		cfg_wdata <= TW'(high_thr);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_two_bank = two_bank;
		cfg_low_thr  = low_thr;
		cfg_high_thr = high_thr;
	endtask

	function automatic switch_tick_t make_tick(int lvl, bit tcon, int sa, bit acon, int sb,
		bit bcon, int mask);
		switch_tick_t t;
		t.trigger_level = 16'(lvl);
		t.trig_con      = tcon;
		t.sig_a         = 16'(sa);
		t.sig_a_con     = acon;
		t.sig_b         = 16'(sb);
		t.sig_b_con     = bcon;
		t.port_mask     = 8'(mask);
		return t;
	endfunction

	// Levels mostly swing across the thresholds so that edges are frequent.
	function automatic switch_tick_t random_tick();
		switch_tick_t t;
		int           lvl;
		case ($urandom_range(0, 9))
			0, 1:    lvl = int'($signed(16'($urandom)));
			2, 3, 4: lvl = cfg_high_thr + int'($urandom_range(0, 32767 - cfg_high_thr));
			5, 6, 7: lvl = cfg_low_thr - int'($urandom_range(0, cfg_low_thr + 32768));
			8:       lvl = cfg_high_thr;
			default: lvl = cfg_low_thr;
		endcase
		t.trigger_level = 16'(lvl);
		t.trig_con      = ($urandom_range(0, 9) != 0);
		t.sig_a         = 16'($urandom);
		t.sig_a_con     = ($urandom_range(0, 4) != 0);
		t.sig_b         = 16'($urandom);
		t.sig_b_con     = ($urandom_range(0, 4) != 0);
		case ($urandom_range(0, 7))
			0:       t.port_mask = 8'h00;
			1:       t.port_mask = 8'hFF;
			2:       t.port_mask = 8'(1 << $urandom_range(0, 7));
			default: t.port_mask = 8'($urandom);
		endcase
		return t;
	endfunction

	task automatic send_random_ticks(input int count);
		for (int n = 0; n < count; n++)
			send_tick(random_tick());
	endtask

	task automatic test_directed_ticks();
		// Level between thresholds keeps the trigger unknown; a disconnected trigger holds it.
		send_tick(make_tick(1000, 1, 16'h1234, 1, 0, 0, 8'h01));
		send_tick(make_tick(2048, 1, 0, 1, 0, 0, 8'h00));
		send_tick(make_tick(-32768, 0, 0, 0, 0, 0, 8'h00));
		send_tick(make_tick(32767, 1, 0, 0, 0, 0, 8'h00));
		send_tick(make_tick(0, 1, 0, 0, 0, 0, 8'hFF));
		send_tick(make_tick(2048, 1, 32767, 1, 0, 0, 8'hFF));
		send_tick(make_tick(0, 1, -32768, 0, 0, 0, 8'hFF));
		// An edge with no patched port leaves the selection and the held values alone.
		send_tick(make_tick(32767, 1, 16'h5A5A, 1, 0, 0, 8'h00));
		send_tick(make_tick(-32768, 1, 0, 0, 0, 0, 8'h01));
		send_tick(make_tick(2048, 1, -32768, 1, 0, 0, 8'h01));
		send_tick(make_tick(0, 1, 0, 0, 0, 0, 8'h80));
		send_tick(make_tick(2048, 1, 32767, 1, 0, 0, 8'h80));
		send_tick(make_tick(0, 1, 0, 0, 0, 0, 8'h40));
		send_tick(make_tick(2048, 1, 16'h0F0F, 1, 0, 0, 8'h40));
		// Two banks: a selection left in the upper half is folded into bank A.
		write_switch_regs(1'b1, 0, 2048);
		send_tick(make_tick(1000, 1, 16'h5555, 1, 16'hAAAA, 1, 8'hFF));
		send_tick(make_tick(0, 1, 0, 0, 0, 0, 8'h11));
		send_tick(make_tick(2048, 1, -32768, 1, 32767, 1, 8'h11));
		send_tick(make_tick(0, 1, 0, 0, 0, 0, 8'hEE));
		send_tick(make_tick(2048, 1, 32767, 1, -32768, 1, 8'hEE));
		send_tick(make_tick(0, 1, 16'h1111, 1, 16'h2222, 0, 8'hFF));
	endtask

	task automatic test_one_bank_random();
		write_switch_regs(1'b0, -1024, 1024);
		send_random_ticks(200);
	endtask

	task automatic test_two_bank_extremes();
		write_switch_regs(1'b1, -32768, 32767);
		send_random_ticks(100);
		write_switch_regs(1'b1, 500, 500);
		send_random_ticks(100);
	endtask

	task automatic test_crossed_thresholds();
		write_switch_regs(1'b1, 3000, -3000);
		send_random_ticks(60);
		write_switch_regs(1'b0, 32767, -32768);
		send_random_ticks(60);
	endtask

	task automatic test_output_backpressure();
		write_switch_regs(1'b1, -2048, 2048);
		hold_request = 300;
		send_random_ticks(40);
	endtask

	task automatic test_drain_pause();
		send_random_ticks(30);
		wait_drained();
		send_random_ticks(30);
	endtask

	task automatic test_no_idle_stream();
		write_switch_regs(1'b0, 0, 2048);
		idle_en = 1'b0;
		send_random_ticks(80);
		write_switch_regs(1'b1, 0, 2048);
		send_random_ticks(80);
	endtask

	initial begin
		for (int i = 0; i < NP; i++)
			held_val[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ticks();
		test_one_bank_random();
		test_two_bank_extremes();
		test_crossed_thresholds();
		test_output_backpressure();
		test_drain_pause();
		test_no_idle_stream();
		wait_drained();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && pending_outputs.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- trigger_advanced_sequential_switch_unit.f -----
rtl/tass_pkg.sv
rtl/trigger_advanced_sequential_switch_unit.sv
dv/tb_top.sv
